// ===== rtl/qtp_pkg.sv =====
// ----------------------------------------------------------------------------
// qtp_pkg
// Shared types, constants and the divider step for the quintic trajectory
// point pipeline.
// ----------------------------------------------------------------------------
package qtp_pkg;

   localparam logic [19:0] US_PER_S     = 20'd1000000;
   localparam int unsigned SDIV_STEPS   = 32;  // s = t*2^31/T quotient bits
   localparam int unsigned VDIV_STEPS   = 32;  // velocity quotient bits
   localparam int unsigned QDIV_STEPS   = 55;  // first acceleration quotient bits
   localparam int unsigned ADIV_STEPS   = 32;  // final acceleration quotient bits

   typedef enum logic [1:0] {
      KIND_EVAL,
      KIND_EARLY,
      KIND_LATE
   } kind_type;

   // per-beat sideband that rides the whole pipe
   typedef struct packed {
      kind_type           kind;
      logic signed [31:0] p0;
      logic signed [31:0] pt;
      logic               dneg;
      logic [32:0]        dm;
   } side_type;

   typedef struct packed {
      side_type    side;
      logic        tb;
      logic [30:0] rem;
      logic [31:0] q;
   } sdiv_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] s;
   } s_res_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] hm;
      logic [31:0] gm;
      logic [33:0] am;
      logic        aneg;
   } poly_res_type;

   typedef struct packed {
      side_type    side;
      logic [31:0] pos;
      logic        psat;
      logic        aneg;
      logic [54:0] yv;
      logic [67:0] na;
   } prod_res_type;

   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] acc;
      logic        sat;
   } rsp_type;

   // one restoring step: returns {new remainder, quotient bit}
   function automatic logic [31:0] div_step(logic [30:0] rem, logic nbit,
                                            logic [30:0] dvs);
      logic [31:0] r2;
      logic [31:0] diff;
      r2   = {rem, nbit};
      diff = r2 - {1'b0, dvs};
      if (r2 >= {1'b0, dvs}) begin
         return {diff[30:0], 1'b1};
      end else begin
         return {r2[30:0], 1'b0};
      end
   endfunction

   // apply sign to a magnitude and clamp to signed 32 bits: {sat, value}
   function automatic logic [32:0] sign_out(logic [31:0] mag, logic neg, logic force_sat);
      logic [31:0] negv;
      negv = 32'd0 - mag;
      if (neg) begin
         if (force_sat || (mag > 32'h8000_0000)) begin
            return {1'b1, 32'h8000_0000};
         end else begin
            return {1'b0, negv};
         end
      end else begin
         if (force_sat || (mag > 32'h7FFF_FFFF)) begin
            return {1'b1, 32'h7FFF_FFFF};
         end else begin
            return {1'b0, mag};
         end
      end
   endfunction

endpackage

// ===== rtl/qtp_sdiv.sv =====
// ----------------------------------------------------------------------------
// qtp_sdiv
// Entry stage (case split, |d|) and pipelined normalized time s = t*2^31/T.
// ----------------------------------------------------------------------------
module qtp_sdiv (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  in_vld,
   input  logic [31:0]           in_t,
   input  logic signed [31:0]    in_p0,
   input  logic signed [31:0]    in_pt,
   input  logic [30:0]           tt,
   output logic                  out_vld,
   output qtp_pkg::s_res_type    out_res
);

   qtp_pkg::sdiv_type stg_ff [qtp_pkg::SDIV_STEPS+1];
   logic              vld_ff [qtp_pkg::SDIV_STEPS+1];
   qtp_pkg::sdiv_type ent_in;
   logic signed [32:0] d;
   logic signed [32:0] dn;

   always_comb begin
      d  = {in_pt[31], in_pt} - {in_p0[31], in_p0};
      dn = -d;
      ent_in.side.kind = qtp_pkg::KIND_EVAL;
      if (in_t[31]) begin
         ent_in.side.kind = qtp_pkg::KIND_EARLY;
      end else if (in_t[30:0] > tt) begin
         ent_in.side.kind = qtp_pkg::KIND_LATE;
      end
      ent_in.side.p0   = in_p0;
      ent_in.side.pt   = in_pt;
      ent_in.side.dneg = d[32];
      ent_in.side.dm   = d[32] ? dn : d;
      ent_in.tb        = in_t[0];
      ent_in.rem       = {1'b0, in_t[30:1]};
      ent_in.q         = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff[0] <= 1'b0;
      end else if (en) begin
         vld_ff[0] <= in_vld;
      end
      if (en) begin
         stg_ff[0] <= ent_in;
      end
   end

   for (genvar k = 0; k < qtp_pkg::SDIV_STEPS; k++) begin : g_step
      qtp_pkg::sdiv_type stg_in;
      logic [31:0]       res;
      always_comb begin
         res        = qtp_pkg::div_step(stg_ff[k].rem, (k == 0) ? stg_ff[k].tb : 1'b0, tt);
         stg_in     = stg_ff[k];
         stg_in.rem = res[31:1];
         stg_in.q   = {stg_ff[k].q[30:0], res[0]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            vld_ff[k+1] <= 1'b0;
         end else if (en) begin
            vld_ff[k+1] <= vld_ff[k];
         end
         if (en) begin
            stg_ff[k+1] <= stg_in;
         end
      end
   end

   assign out_vld      = vld_ff[qtp_pkg::SDIV_STEPS];
   assign out_res.side = stg_ff[qtp_pkg::SDIV_STEPS].side;
   assign out_res.s    = stg_ff[qtp_pkg::SDIV_STEPS].q;

endmodule

// ===== rtl/qtp_poly.sv =====
// ----------------------------------------------------------------------------
// qtp_poly
// Powers s^2..s^5 (one multiply per stage) and the h, g, a blends.
// ----------------------------------------------------------------------------
module qtp_poly (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  qtp_pkg::s_res_type     in_res,
   output logic                   out_vld,
   output qtp_pkg::poly_res_type  out_res
);

   typedef struct packed {
      qtp_pkg::side_type side;
      logic [31:0]       s;
      logic [31:0]       s2;
      logic [31:0]       s3;
      logic [31:0]       s4;
      logic [31:0]       s5;
   } pw_type;

   function automatic logic [31:0] mul_q31(logic [31:0] a, logic [31:0] b);
      logic [63:0] p;
      p = a * b;
      return p[62:31];
   endfunction

   function automatic logic signed [39:0] sx(logic [31:0] x);
      return $signed({8'd0, x});
   endfunction

   pw_type                p1_ff, p2_ff, p3_ff, p4_ff;
   pw_type                p1_in, p2_in, p3_in, p4_in;
   logic [4:0]            vld_ff;
   qtp_pkg::poly_res_type res_ff, res_in;
   logic signed [39:0]    hv, gv, av, amag;

   always_comb begin
      p1_in      = '0;
      p1_in.side = in_res.side;
      p1_in.s    = in_res.s;
      p1_in.s2   = mul_q31(in_res.s, in_res.s);
      p2_in      = p1_ff;
      p2_in.s3   = mul_q31(p1_ff.s2, p1_ff.s);
      p3_in      = p2_ff;
      p3_in.s4   = mul_q31(p2_ff.s3, p2_ff.s);
      p4_in      = p3_ff;
      p4_in.s5   = mul_q31(p3_ff.s4, p3_ff.s);

      hv = 40'sd10 * sx(p4_ff.s3) - 40'sd15 * sx(p4_ff.s4) + 40'sd6 * sx(p4_ff.s5);
      gv = 40'sd30 * sx(p4_ff.s2) - 40'sd60 * sx(p4_ff.s3) + 40'sd30 * sx(p4_ff.s4);
      av = 40'sd60 * sx(p4_ff.s) - 40'sd180 * sx(p4_ff.s2) + 40'sd120 * sx(p4_ff.s3);
      amag = av[39] ? -av : av;

      res_in.side = p4_ff.side;
      if (hv[39]) begin
         res_in.hm = '0;
      end else if (hv > 40'sh00_8000_0000) begin
         res_in.hm = 32'h8000_0000;
      end else begin
         res_in.hm = hv[31:0];
      end
      res_in.gm   = gv[39] ? 32'd0 : gv[31:0];
      res_in.am   = amag[33:0];
      res_in.aneg = av[39];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[3:0], in_vld};
      end
      if (en) begin
         p1_ff  <= p1_in;
         p2_ff  <= p2_in;
         p3_ff  <= p3_in;
         p4_ff  <= p4_in;
         res_ff <= res_in;
      end
   end

   assign out_vld = vld_ff[4];
   assign out_res = res_ff;

endmodule

// ===== rtl/qtp_prod.sv =====
// ----------------------------------------------------------------------------
// qtp_prod
// Products with |d|: position (with clamp), velocity numerator and first
// acceleration numerator, split into partial products.
// ----------------------------------------------------------------------------
module qtp_prod (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  qtp_pkg::poly_res_type  in_res,
   input  logic [30:0]            tt,
   output logic                   out_vld,
   output qtp_pkg::prod_res_type  out_res
);

   typedef struct packed {
      qtp_pkg::side_type side;
      logic [64:0]       pd;
      logic [52:0]       vd;
      logic [49:0]       ad_lo;
      logic [49:0]       ad_hi;
      logic [31:0]       gm;
      logic              aneg;
   } m1_type;

   typedef struct packed {
      qtp_pkg::side_type side;
      logic [31:0]       pos;
      logic              psat;
      logic              aneg;
      logic [68:0]       v_lo;
      logic [68:0]       v_hi;
      logic [67:0]       na;
   } m2_type;

   m1_type                m1_ff, m1_in;
   m2_type                m2_ff, m2_in;
   qtp_pkg::prod_res_type m3_ff, m3_in;
   logic [2:0]            vld_ff;
   logic [65:0]           rsum;
   logic signed [35:0]    pos_w;
   logic [85:0]           ysum;

   always_comb begin
      m1_in.side  = in_res.side;
      m1_in.pd    = in_res.side.dm * in_res.hm;
      m1_in.vd    = in_res.side.dm * qtp_pkg::US_PER_S;
      m1_in.ad_lo = in_res.side.dm * in_res.am[16:0];
      m1_in.ad_hi = in_res.side.dm * in_res.am[33:17];
      m1_in.gm    = in_res.gm;
      m1_in.aneg  = in_res.aneg;

      // position: round half up, then add or subtract from start
      rsum = {1'b0, m1_ff.pd} + (66'd1 << 30);
      if (m1_ff.side.dneg) begin
         pos_w = {{4{m1_ff.side.p0[31]}}, m1_ff.side.p0} - $signed({1'b0, rsum[65:31]});
      end else begin
         pos_w = {{4{m1_ff.side.p0[31]}}, m1_ff.side.p0} + $signed({1'b0, rsum[65:31]});
      end
      m2_in.side = m1_ff.side;
      m2_in.aneg = m1_ff.aneg;
      if (pos_w > 36'sh0_7FFF_FFFF) begin
         m2_in.pos  = 32'h7FFF_FFFF;
         m2_in.psat = 1'b1;
      end else if (pos_w < -36'sh0_8000_0000) begin
         m2_in.pos  = 32'h8000_0000;
         m2_in.psat = 1'b1;
      end else begin
         m2_in.pos  = pos_w[31:0];
         m2_in.psat = 1'b0;
      end
      m2_in.v_lo = m1_ff.vd * m1_ff.gm[15:0];
      m2_in.v_hi = m1_ff.vd * m1_ff.gm[31:16];
      m2_in.na   = {1'b0, m1_ff.ad_hi, 17'd0} + {18'd0, m1_ff.ad_lo}
                   + {38'd0, tt[30:1]};

      // velocity numerator, scaled down by 2^31 ahead of the divide by T
      ysum = {m2_ff.v_hi, 16'd0} + {1'b0, 16'd0, m2_ff.v_lo} + {25'd0, tt, 30'd0};
      m3_in.side = m2_ff.side;
      m3_in.pos  = m2_ff.pos;
      m3_in.psat = m2_ff.psat;
      m3_in.aneg = m2_ff.aneg;
      m3_in.yv   = ysum[85:31];
      m3_in.na   = m2_ff.na;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (en) begin
         vld_ff <= {vld_ff[1:0], in_vld};
      end
      if (en) begin
         m1_ff <= m1_in;
         m2_ff <= m2_in;
         m3_ff <= m3_in;
      end
   end

   assign out_vld = vld_ff[2];
   assign out_res = m3_ff;

endmodule

// ===== rtl/qtp_div.sv =====
// ----------------------------------------------------------------------------
// qtp_div
// Pipelined divides by T for velocity and acceleration, the 10^12 scaling,
// sign and clamp, and the result register.
// ----------------------------------------------------------------------------
module qtp_div (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   en,
   input  logic                   in_vld,
   input  qtp_pkg::prod_res_type  in_res,
   input  logic [30:0]            tt,
   output logic                   out_vld,
   output qtp_pkg::rsp_type       out_res
);

   localparam int unsigned NB = qtp_pkg::QDIV_STEPS;
   localparam int unsigned ND = qtp_pkg::ADIV_STEPS;

   typedef struct packed {
      qtp_pkg::side_type side;
      logic [31:0]       pos;
      logic              psat;
      logic              aneg;
      logic              vsat;
      logic [30:0]       vrem;
      logic [31:0]       vnum;
      logic [31:0]       vq;
      logic              asat;
      logic [30:0]       arem;
      logic [54:0]       anum;
      logic [54:0]       aq;
   } bdiv_type;

   typedef struct packed {
      qtp_pkg::side_type side;
      logic [31:0]       pos;
      logic              psat;
      logic              aneg;
      logic              vsat;
      logic [31:0]       vq;
      logic              asat;
      logic [57:0]       lo;
      logic [56:0]       hi;
      logic [95:0]       wide;
   } cmul_type;

   typedef struct packed {
      qtp_pkg::side_type side;
      logic [31:0]       pos;
      logic              psat;
      logic              aneg;
      logic              vsat;
      logic [31:0]       vq;
      logic              asat;
      logic [30:0]       rem;
      logic [31:0]       num;
      logic [31:0]       q;
   } ddiv_type;

   bdiv_type         b_ff [NB+1];
   logic             bv_ff [NB+1];
   bdiv_type         b0_in;
   cmul_type         c_ff [4];
   cmul_type         c_in [4];
   logic [3:0]       cv_ff;
   ddiv_type         d_ff [ND+1];
   logic             dv_ff [ND+1];
   ddiv_type         d0_in;
   qtp_pkg::rsp_type r_ff, r_in;
   logic             rv_ff;
   logic [32:0]      vo, ao;
   logic [32:0]      atop;

   // divider entry: overflow checks and first remainders
   always_comb begin
      b0_in.side = in_res.side;
      b0_in.pos  = in_res.pos;
      b0_in.psat = in_res.psat;
      b0_in.aneg = in_res.aneg;
      b0_in.vsat = {8'd0, in_res.yv[54:32]} >= tt;
      b0_in.vrem = {8'd0, in_res.yv[54:32]};
      b0_in.vnum = in_res.yv[31:0];
      b0_in.vq   = '0;
      b0_in.asat = {18'd0, in_res.na[67:55]} >= tt;
      b0_in.arem = {18'd0, in_res.na[67:55]};
      b0_in.anum = in_res.na[54:0];
      b0_in.aq   = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         bv_ff[0] <= 1'b0;
      end else if (en) begin
         bv_ff[0] <= in_vld;
      end
      if (en) begin
         b_ff[0] <= b0_in;
      end
   end

   for (genvar k = 0; k < NB; k++) begin : g_bstep
      bdiv_type    b_in;
      logic [31:0] vres, ares;
      always_comb begin
         vres      = qtp_pkg::div_step(b_ff[k].vrem, b_ff[k].vnum[31], tt);
         ares      = qtp_pkg::div_step(b_ff[k].arem, b_ff[k].anum[54], tt);
         b_in      = b_ff[k];
         b_in.arem = ares[31:1];
         b_in.anum = {b_ff[k].anum[53:0], 1'b0};
         b_in.aq   = {b_ff[k].aq[53:0], ares[0]};
         if (k < qtp_pkg::VDIV_STEPS) begin
            b_in.vrem = vres[31:1];
            b_in.vnum = {b_ff[k].vnum[30:0], 1'b0};
            b_in.vq   = {b_ff[k].vq[30:0], vres[0]};
         end
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            bv_ff[k+1] <= 1'b0;
         end else if (en) begin
            bv_ff[k+1] <= bv_ff[k];
         end
         if (en) begin
            b_ff[k+1] <= b_in;
         end
      end
   end

   // q1 * 10^6 * 10^6 + T*2^30, in partial products
   always_comb begin
      c_in[0].side = b_ff[NB].side;
      c_in[0].pos  = b_ff[NB].pos;
      c_in[0].psat = b_ff[NB].psat;
      c_in[0].aneg = b_ff[NB].aneg;
      c_in[0].vsat = b_ff[NB].vsat;
      c_in[0].vq   = b_ff[NB].vq;
      c_in[0].asat = b_ff[NB].asat;
      c_in[0].lo   = 58'(b_ff[NB].aq[27:0]) * qtp_pkg::US_PER_S;
      c_in[0].hi   = 57'(b_ff[NB].aq[54:28]) * qtp_pkg::US_PER_S;
      c_in[0].wide = '0;

      c_in[1]      = c_ff[0];
      c_in[1].wide = {11'd0, c_ff[0].hi[56:0], 28'd0} + {38'd0, c_ff[0].lo};

      c_in[2]      = c_ff[1];
      c_in[2].lo   = c_ff[1].wide[37:0] * qtp_pkg::US_PER_S;
      c_in[2].hi   = c_ff[1].wide[74:38] * qtp_pkg::US_PER_S;

      c_in[3]      = c_ff[2];
      c_in[3].wide = {1'b0, c_ff[2].hi, 38'd0} + {38'd0, c_ff[2].lo}
                     + {35'd0, tt, 30'd0};
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cv_ff <= '0;
      end else if (en) begin
         cv_ff <= {cv_ff[2:0], bv_ff[NB]};
      end
      if (en) begin
         for (int i = 0; i < 4; i++) begin
            c_ff[i] <= c_in[i];
         end
      end
   end

   // final acceleration divide entry
   always_comb begin
      atop       = c_ff[3].wide[95:63];
      d0_in.side = c_ff[3].side;
      d0_in.pos  = c_ff[3].pos;
      d0_in.psat = c_ff[3].psat;
      d0_in.aneg = c_ff[3].aneg;
      d0_in.vsat = c_ff[3].vsat;
      d0_in.vq   = c_ff[3].vq;
      d0_in.asat = c_ff[3].asat || (atop >= {2'b0, tt});
      d0_in.rem  = atop[30:0];
      d0_in.num  = c_ff[3].wide[62:31];
      d0_in.q    = '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         dv_ff[0] <= 1'b0;
      end else if (en) begin
         dv_ff[0] <= cv_ff[3];
      end
      if (en) begin
         d_ff[0] <= d0_in;
      end
   end

   for (genvar k = 0; k < ND; k++) begin : g_dstep
      ddiv_type    d_in;
      logic [31:0] res;
      always_comb begin
         res      = qtp_pkg::div_step(d_ff[k].rem, d_ff[k].num[31], tt);
         d_in     = d_ff[k];
         d_in.rem = res[31:1];
         d_in.num = {d_ff[k].num[30:0], 1'b0};
         d_in.q   = {d_ff[k].q[30:0], res[0]};
      end
      always_ff @(posedge clock) begin
         if (reset) begin
            dv_ff[k+1] <= 1'b0;
         end else if (en) begin
            dv_ff[k+1] <= dv_ff[k];
         end
         if (en) begin
            d_ff[k+1] <= d_in;
         end
      end
   end

   // sign, clamp and the early / late cases
   always_comb begin
      vo = qtp_pkg::sign_out(d_ff[ND].vq, d_ff[ND].side.dneg, d_ff[ND].vsat);
      ao = qtp_pkg::sign_out(d_ff[ND].q, d_ff[ND].side.dneg ^ d_ff[ND].aneg,
                             d_ff[ND].asat);
      case (d_ff[ND].side.kind)
         qtp_pkg::KIND_EARLY: begin
            r_in = '{pos: d_ff[ND].side.p0, vel: '0, acc: '0, sat: 1'b0};
         end
         qtp_pkg::KIND_LATE: begin
            r_in = '{pos: d_ff[ND].side.pt, vel: '0, acc: '0, sat: 1'b0};
         end
         default: begin
            r_in = '{pos: d_ff[ND].pos, vel: vo[31:0], acc: ao[31:0],
                     sat: d_ff[ND].psat | vo[32] | ao[32]};
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rv_ff <= 1'b0;
      end else if (en) begin
         rv_ff <= dv_ff[ND];
      end
      if (en) begin
         r_ff <= r_in;
      end
   end

   assign out_vld = rv_ff;
   assign out_res = r_ff;

endmodule

// ===== rtl/quintic_trajectory_point.sv =====
// ----------------------------------------------------------------------------
// quintic_trajectory_point
// Minimum-jerk (quintic) joint trajectory sampler: position, velocity and
// acceleration of one joint at a given time, fully pipelined.
// ----------------------------------------------------------------------------
// One beat in per clock while the result stream is not stalled, one result
// beat out per input beat, in order. The pipe runs, in order: the bit-serial
// s = t/T divider, the power chain, the |d| products, the paired velocity /
// first acceleration divide by T, the 10^12 scaling, the final acceleration
// divide and one result register. All divides retire one quotient bit per
// stage against total_time, so the pipe depth is set by those quotient
// widths. A stalled result freezes the whole pipe; nothing is dropped or
// repeated. total_time must be written only while no beats are in flight;
// 0 is treated as 1 us.
module quintic_trajectory_point (
   input  logic        clock,
   input  logic        reset,
   // input stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,   // [31:0] elapsed_time, [63:32] start_position,
                                    // [95:64] target_position
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [95:0] rsp_tdata,   // [31:0] position, [63:32] velocity,
                                    // [95:64] acceleration
   output logic        rsp_tuser,   // [0] saturated
   // register port
   input  logic        csr_psel,
   input  logic        csr_penable,
   input  logic        csr_pwrite,
   input  logic [2:0]  csr_paddr,
   input  logic [31:0] csr_pwdata,
   output logic [31:0] csr_prdata,
   output logic        csr_pready
);

   logic [30:0]            total_time_ff;
   logic [30:0]            tt;
   logic                   en;
   logic                   s_vld, p_vld, m_vld;
   qtp_pkg::s_res_type     s_res;
   qtp_pkg::poly_res_type  p_res;
   qtp_pkg::prod_res_type  m_res;
   qtp_pkg::rsp_type       r_res;

   // register at byte 0: total_time
   always_ff @(posedge clock) begin
      if (reset) begin
         total_time_ff <= 31'd1000000;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready
                   && !csr_paddr[2]) begin
         total_time_ff <= csr_pwdata[30:0];
      end
   end

   assign csr_pready = 1'b1;
   assign csr_prdata = csr_paddr[2] ? 32'd0 : {1'b0, total_time_ff};

   assign tt = (total_time_ff == 31'd0) ? 31'd1 : total_time_ff;

   // global advance: result register empty or being taken
   assign en         = !rsp_tvalid || rsp_tready;
   assign req_tready = en;

   qtp_sdiv u_sdiv (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (req_tvalid),
      .in_t    (req_tdata[31:0]),
      .in_p0   (req_tdata[63:32]),
      .in_pt   (req_tdata[95:64]),
      .tt      (tt),
      .out_vld (s_vld),
      .out_res (s_res)
   );

   qtp_poly u_poly (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (s_vld),
      .in_res  (s_res),
      .out_vld (p_vld),
      .out_res (p_res)
   );

   qtp_prod u_prod (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (p_vld),
      .in_res  (p_res),
      .tt      (tt),
      .out_vld (m_vld),
      .out_res (m_res)
   );

   qtp_div u_div (
      .clock   (clock),
      .reset   (reset),
      .en      (en),
      .in_vld  (m_vld),
      .in_res  (m_res),
      .tt      (tt),
      .out_vld (rsp_tvalid),
      .out_res (r_res)
   );

   assign rsp_tdata = {r_res.acc, r_res.vel, r_res.pos};
   assign rsp_tuser = r_res.sat;

endmodule

// ===== test/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for quintic_trajectory_point: random and directed joint
// samples, streamed with random idling on both sides, compared beat by beat
// against a bit-exact predictor of the minimum-jerk move.
// ----------------------------------------------------------------------------
module tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int          PIPE_LATENCY = 135;
   localparam int          CYCLE_LIMIT  = 400000;
   localparam logic [2:0]  ADDR_TOTAL_TIME = 3'd0;
   localparam logic [63:0] US  = 64'd1000000;
   localparam logic [63:0] US2 = 64'd1000000000000;
   localparam logic [63:0] Q31 = 64'h8000_0000;

   typedef struct packed {
      logic signed [31:0] t;
      logic signed [31:0] p0;
      logic signed [31:0] pt;
   } sample_type;

   typedef struct packed {
      logic [31:0] pos;
      logic [31:0] vel;
      logic [31:0] acc;
      logic        sat;
   } point_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [95:0] rsp_tdata;
   logic        rsp_tuser;
   logic        csr_psel = 1'b0, csr_penable = 1'b0, csr_pwrite = 1'b0;
   logic [2:0]  csr_paddr = '0;
   logic [31:0] csr_pwdata = '0;
   logic [31:0] csr_prdata;
   logic        csr_pready;

   quintic_trajectory_point dut (.*);

   always #5 clock = ~clock;

   // predictor copy of the duration register
   logic [30:0] move_time = 31'd1000000;

   sample_type pending_samples[$];
   point_type  expected_points[$];
   int      errors = 0;
   int      cycles = 0;
   int      beats_out = 0;
   int      sat_seen = 0;
   int      send_idle = 30;   // percent
   int      recv_idle = 49;
   int      hold_off = 0;     // receiver long stall, in cycles

   // round(a*b/c) half up on a 128-bit product, saturating
   function automatic logic [63:0] scale_div(logic [63:0] a, logic [63:0] b,
                                              logic [63:0] c, ref logic sat);
      logic [127:0] prod;
      logic [127:0] quo;
      prod = 128'(a) * 128'(b) + 128'(c >> 1);
      if ((prod >> 64) >= 128'(c)) begin
         sat = 1'b1;
         return '1;
      end
      quo = prod / 128'(c);
      return quo[63:0];
   endfunction

   function automatic logic [31:0] clamp_signed(logic [63:0] mag, logic neg, ref logic sat);
      if (neg) begin
         if (mag > Q31) begin
            mag = Q31;
            sat = 1'b1;
         end
         return 32'd0 - mag[31:0];
      end
      if (mag > Q31 - 1) begin
         mag = Q31 - 1;
         sat = 1'b1;
      end
      return mag[31:0];
   endfunction

   function automatic point_type trajectory_point(sample_type smp);
      point_type   r;
      logic [63:0] dur, s, s2, s3, s4, s5, dm, hm, gm, am, delta, vm, q1, acm;
      logic signed [63:0] d, h, g, a, pos;
      logic        dneg, aneg, sat;
      dur = (move_time == 0) ? 64'd1 : 64'(move_time);
      d = 64'(smp.pt) - 64'(smp.p0);
      dneg = d < 0;
      dm = dneg ? -d : d;
      sat = 1'b0;
      r = '0;
      if (smp.t < 0) begin
         r.pos = smp.p0;
         return r;
      end
      if (64'(smp.t) > dur) begin
         r.pos = smp.pt;
         return r;
      end
      s  = (64'(smp.t) << 31) / dur;
      s2 = (s * s) >> 31;
      s3 = (s2 * s) >> 31;
      s4 = (s3 * s) >> 31;
      s5 = (s4 * s) >> 31;
      h = 10 * $signed(s3) - 15 * $signed(s4) + 6 * $signed(s5);
      if (h < 0) h = 0;
      if (h > $signed(Q31)) h = Q31;
      g = 30 * $signed(s2) - 60 * $signed(s3) + 30 * $signed(s4);
      if (g < 0) g = 0;
      a = 60 * $signed(s) - 180 * $signed(s2) + 120 * $signed(s3);
      aneg = a < 0;
      am = aneg ? -a : a;
      hm = h;
      gm = g;
      delta = (dm * hm + (Q31 >> 1)) >> 31;
      pos = dneg ? 64'(smp.p0) - $signed(delta) : 64'(smp.p0) + $signed(delta);
      if (pos > 64'sh7FFF_FFFF) begin
         pos = 64'sh7FFF_FFFF;
         sat = 1'b1;
      end
      if (pos < -64'sh8000_0000) begin
         pos = -64'sh8000_0000;
         sat = 1'b1;
      end
      r.pos = pos[31:0];
      vm = scale_div(dm * gm, US, dur << 31, sat);
      r.vel = clamp_signed(vm, dneg, sat);
      q1  = scale_div(dm, am, dur, sat);
      acm = scale_div(q1, US2, dur << 31, sat);
      r.acc = clamp_signed(acm, dneg != aneg, sat);
      r.sat = sat;
      return r;
   endfunction

   // driver: pops pending samples, random gaps
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (!reset) begin
         if (!req_tvalid || req_tready) begin
            if (pending_samples.size() > 0 && $urandom_range(99) >= send_idle) begin
               sample_type smp;
               smp = pending_samples.pop_front();
               expected_points.push_back(trajectory_point(smp));
               req_tdata  <= {smp.pt, smp.p0, smp.t};
               req_tvalid <= 1'b1;
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // monitor: random back-pressure, long hold-off on request
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_tvalid && rsp_tready) begin
            point_type want, got;
            got = {rsp_tdata[31:0], rsp_tdata[63:32], rsp_tdata[95:64], rsp_tuser};
            beats_out <= beats_out + 1;
            if (rsp_tuser) sat_seen <= sat_seen + 1;
            if (expected_points.size() == 0) begin
               $display("%0t: unexpected beat %h", $time, got);
               errors <= errors + 1;
            end else begin
               want = expected_points.pop_front();
               if (got.pos !== want.pos)
                  $display("%0t: position exp %h got %h", $time, want.pos, got.pos);
               if (got.vel !== want.vel)
                  $display("%0t: velocity exp %h got %h", $time, want.vel, got.vel);
               if (got.acc !== want.acc)
                  $display("%0t: accel exp %h got %h", $time, want.acc, got.acc);
               if (got.sat !== want.sat)
                  $display("%0t: saturated exp %b got %b", $time, want.sat, got.sat);
               if (got !== want) errors <= errors + 1;
            end
         end
         if (hold_off > 0) begin
            hold_off   <= hold_off - 1;
            rsp_tready <= 1'b0;
         end else begin
            rsp_tready <= $urandom_range(99) >= recv_idle;
         end
      end
   end

   always @(posedge clock) begin
      if (cycles > CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // register write: setup then access cycle
   task automatic write_reg(logic [2:0] addr, logic [31:0] val);
      @(posedge clock);
      csr_psel <= 1'b1; csr_pwrite <= 1'b1; csr_paddr <= addr; csr_pwdata <= val;
      @(posedge clock);
      csr_penable <= 1'b1;
      @(posedge clock);
      csr_psel <= 1'b0; csr_penable <= 1'b0; csr_pwrite <= 1'b0;
      if (addr == ADDR_TOTAL_TIME) move_time = val[30:0];
   endtask

   task automatic drain_pipe();
      while (pending_samples.size() > 0 || expected_points.size() > 0 || req_tvalid)
         @(posedge clock);
      repeat (PIPE_LATENCY + 10) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_pos();
      case ($urandom_range(3))
         0: return $urandom;
         1: return $urandom_range(4000) - 2000;
         2: return {$urandom_range(1) ? 8'hFF : 8'h00, 24'($urandom)};
         default: return $urandom_range(1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      endcase
   endfunction

   function automatic sample_type rand_sample();
      sample_type  smp;
      logic [31:0] dur;
      dur = (move_time == 0) ? 1 : move_time;
      case ($urandom_range(9))
         0: smp.t = $urandom;
         1: smp.t = -$signed(32'($urandom_range(1000)));
         2: smp.t = dur + $urandom_range(1, 1000);
         3: smp.t = dur;
         default: smp.t = 32'((64'($urandom) * dur) >> 32);
      endcase
      smp.p0 = rand_pos();
      smp.pt = rand_pos();
      return smp;
   endfunction

   task automatic run_phase(logic [31:0] dur, int count);
      write_reg(ADDR_TOTAL_TIME, dur);
      for (int i = 0; i < count; i++) pending_samples.push_back(rand_sample());
      drain_pipe();
   endtask

   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      // directed: reset duration, edges of time and position
      pending_samples.push_back('{32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000});
      pending_samples.push_back('{-1, 100, 200});
      pending_samples.push_back('{0, 32'sh8000_0000, 32'sh7FFF_FFFF});
      pending_samples.push_back('{1, 0, 32'sh7FFF_FFFF});
      pending_samples.push_back('{500000, 32'sh7FFF_FFFF, 32'sh8000_0000});
      pending_samples.push_back('{211325, 0, 32'sh0100_0000});
      pending_samples.push_back('{999999, -5, 5});
      pending_samples.push_back('{1000000, 32'sh8000_0000, 32'sh7FFF_FFFF});
      pending_samples.push_back('{1000001, 1, 2});
      pending_samples.push_back('{32'sh7FFF_FFFF, 32'sh1234_5678, 32'shFFFF_FFFF});
      pending_samples.push_back('{250000, 77, 77});
      drain_pipe();
      // zero duration behaves as one microsecond
      write_reg(ADDR_TOTAL_TIME, 0);
      pending_samples.push_back('{0, 32'sh8000_0000, 32'sh7FFF_FFFF});
      pending_samples.push_back('{1, 0, 32'sh7FFF_FFFF});
      pending_samples.push_back('{2, 3, 4});
      drain_pipe();
      // short moves saturate velocity and acceleration
      run_phase(1, 60);
      run_phase(37, 100);
      // long stall: receiver holds off while sender keeps offering
      write_reg(ADDR_TOTAL_TIME, 5000);
      for (int i = 0; i < 250; i++) pending_samples.push_back(rand_sample());
      hold_off = 400;
      drain_pipe();
      send_idle = 49; recv_idle = 30;
      run_phase(31'h7FFF_FFFF, 80);
      run_phase($urandom_range(1, 100000), 60);
      send_idle = 0; recv_idle = 0;
      run_phase(1000000, 60);
      run_phase($urandom, 40);
      $display("Streamed %0d result beats over several move durations, %0d saturated.",
               beats_out, sat_seen);
      if (errors == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end
endmodule

// ===== sim.f =====
rtl/qtp_pkg.sv
rtl/qtp_sdiv.sv
rtl/qtp_poly.sv
rtl/qtp_prod.sv
rtl/qtp_div.sv
rtl/quintic_trajectory_point.sv
test/tb.sv
